// File: rtl/core/assert_macros.svh
// Assertion macros shared by the filter core.
// No dependencies; each assertion is compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/mmas_pkg.sv
// Package for the moving average scaler: sizes, register indexes and shared types.
// No dependencies.
`default_nettype none

package mmas_pkg;

    // Filter geometry
    localparam int CHANNELS    = 5;
    localparam int WINDOW      = 10;
    localparam int SAMPLE_BITS = 12;

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int ROW_W = CHANNELS * SAMPLE_BITS;

    // Division by WINDOW: multiply by floor(2^DIV_SH / WINDOW), then one correction step
    localparam int DIV_SH     = SUM_W;
    localparam int DIV_RECIP  = (2 ** DIV_SH) / WINDOW;
    localparam int DIV_PROD_W = SUM_W + DIV_SH;

    // Scaling
    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 16;
    localparam int MUL_W     = SAMPLE_BITS + GAIN_W;
    localparam int SHR_W     = MUL_W - GAIN_FRAC;
    localparam int CUR_W     = 16;
    localparam int VOLT_W    = 17;

    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = GAIN_W'(114810);
    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST = GAIN_W'(1115409);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN = CFG_IDX_W'(1);

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_vec_t;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]       sum_vec_t;

    typedef struct packed {
        logic [GAIN_W-1:0] current;
        logic [GAIN_W-1:0] voltage;
    } gain_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/mmas_if.sv
// Stream interfaces of the scaler: ADC scan words in, result words out.
// Depends on mmas_pkg.
`default_nettype none

interface scan_if;
    logic                               valid;
    logic                               ready;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   sample_a;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   sample_b;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   sample_c;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   sample_d;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   sample_bus;

    modport source (output valid, sample_a, sample_b, sample_c, sample_d, sample_bus,
                    input ready);
    modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, sample_bus,
                    output ready);
endinterface

interface result_if;
    logic                               valid;
    logic                               ready;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   average_a;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   average_b;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   average_c;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   average_d;
    logic [mmas_pkg::SAMPLE_BITS-1:0]   average_bus;
    logic [mmas_pkg::CUR_W-1:0]         current_a_ma;
    logic [mmas_pkg::CUR_W-1:0]         current_b_ma;
    logic [mmas_pkg::CUR_W-1:0]         current_c_ma;
    logic [mmas_pkg::CUR_W-1:0]         current_d_ma;
    logic [mmas_pkg::VOLT_W-1:0]        bus_voltage_mv;

    modport source (output valid, average_a, average_b, average_c, average_d, average_bus,
                    current_a_ma, current_b_ma, current_c_ma, current_d_ma,
                    bus_voltage_mv, input ready);
    modport sink   (input valid, average_a, average_b, average_c, average_d, average_bus,
                    current_a_ma, current_b_ma, current_c_ma, current_d_ma,
                    bus_voltage_mv, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mmas_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module mmas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mmas_window.sv
// Window stage: per-channel sample window in RAM, running sums, shared window position.
// Depends on mmas_pkg, scan_if, mmas_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mmas_window (
    input  wire logic               clk,
    input  wire logic               rst_n,
    scan_if.sink                    scan,
    output logic                    sums_valid,
    input  wire logic               sums_ready,
    output mmas_pkg::sum_vec_t      sums
);
    import mmas_pkg::*;

    logic                   accept;
    logic                   s1_adv;
    logic                   s1_fire;
    sample_vec_t            in_samples;
    sample_vec_t            old_row;
    sum_vec_t               sum_new;
    logic                   sums_ok;

    logic [POS_W-1:0]       pos_reg,       pos_next;
    logic [WINDOW-1:0]      row_valid_reg, row_valid_next;
    logic                   s1_v_reg,      s1_v_next;
    logic [POS_W-1:0]       s1_pos_reg;
    sample_vec_t            s1_samp_reg;
    logic                   s1_old_valid_reg;
    sum_vec_t               sum_reg,       sum_next;
    logic                   out_v_reg,     out_v_next;
    sum_vec_t               out_sum_reg;

    assign in_samples[0] = scan.sample_a;
    assign in_samples[1] = scan.sample_b;
    assign in_samples[2] = scan.sample_c;
    assign in_samples[3] = scan.sample_d;
    assign in_samples[4] = scan.sample_bus;

    // Handshake: stage 1 moves when the sum register is empty or drained
    assign s1_adv     = !out_v_reg || sums_ready;
    assign s1_fire    = s1_v_reg && s1_adv;
    assign scan.ready = !s1_v_reg || s1_adv;
    assign accept     = scan.valid && scan.ready;

    // Window row per scan: read at accept, written back when the word leaves stage 1
    mmas_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW)
    ) u_window_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_pos_reg),
        .wdata (s1_samp_reg),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (old_row)
    );

    // Running sum update; rows never written read as zero
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            sum_new[ch] = sum_reg[ch]
                        - (s1_old_valid_reg ? SUM_W'(old_row[ch]) : SUM_W'(0))
                        + SUM_W'(s1_samp_reg[ch]);
        end
    end

    // Next state of the control registers
    always_comb
    begin
        pos_next       = pos_reg;
        row_valid_next = row_valid_reg;
        sum_next       = sum_reg;
        s1_v_next      = scan.ready ? scan.valid : s1_v_reg;
        out_v_next     = s1_adv ? s1_v_reg : out_v_reg;
        if (accept)
        begin
            pos_next = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + POS_W'(1);
        end
        if (s1_fire)
        begin
            row_valid_next[s1_pos_reg] = 1'b1;
            sum_next                   = sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            row_valid_reg <= '0;
            s1_v_reg      <= 1'b0;
            sum_reg       <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            row_valid_reg <= row_valid_next;
            s1_v_reg      <= s1_v_next;
            sum_reg       <= sum_next;
            out_v_reg     <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg       <= pos_reg;
            s1_samp_reg      <= in_samples;
            s1_old_valid_reg <= row_valid_reg[pos_reg];
        end
        if (s1_fire)
        begin
            out_sum_reg <= sum_new;
        end
    end

    assign sums_valid = out_v_reg;
    assign sums       = out_sum_reg;

    // Sums can never exceed a full window of maximum samples
    always_comb
    begin
        sums_ok = 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (int'(sum_reg[ch]) > WINDOW * (2 ** SAMPLE_BITS - 1))
            begin
                sums_ok = 1'b0;
            end
        end
    end

    `ASSERT_NEVER(a_rw_same_row, clk, rst_n,
        s1_fire && accept && (s1_pos_reg == pos_reg),
        "window row read and written in the same cycle")
    `ASSERT_PROP(a_pos_range, clk, rst_n, int'(pos_reg) < WINDOW,
        "window position out of range")
    `ASSERT_PROP(a_pos_step, clk, rst_n,
        accept |=> (pos_reg == (($past(pos_reg) == POS_W'(WINDOW - 1))
                                ? POS_W'(0) : $past(pos_reg) + POS_W'(1))),
        "window position did not advance by one")
    `ASSERT_PROP(a_sums_bound, clk, rst_n, sums_ok, "running sum exceeds window capacity")

endmodule

`default_nettype wire

// File: rtl/core/mmas_scale.sv
// Scale pipeline: window average by reciprocal multiply, then Q16 gain and saturation.
// Depends on mmas_pkg and result_if.
`default_nettype none

module mmas_scale (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sums_valid,
    output logic                        sums_ready,
    input  wire mmas_pkg::sum_vec_t     sums,
    input  wire mmas_pkg::gain_cfg_t    gains,
    result_if.source                    result
);
    import mmas_pkg::*;

    typedef logic [CHANNELS-1:0][DIV_PROD_W-1:0] div_vec_t;
    typedef logic [CHANNELS-1:0][MUL_W-1:0]      mul_vec_t;
    typedef logic [CHANNELS-1:0][VOLT_W-1:0]     eng_vec_t;

    logic           en_div, en_avg, en_mul, en_out;
    div_vec_t       div_prod;
    sample_vec_t    avg_calc;
    mul_vec_t       mul_prod;
    eng_vec_t       eng_calc;

    logic           v_div_reg, v_div_next;
    logic           v_avg_reg, v_avg_next;
    logic           v_mul_reg, v_mul_next;
    logic           v_out_reg, v_out_next;
    div_vec_t       div_prod_reg;
    sum_vec_t       div_sum_reg;
    sample_vec_t    avg_reg;
    mul_vec_t       mul_prod_reg;
    sample_vec_t    mul_avg_reg;
    sample_vec_t    out_avg_reg;
    eng_vec_t       out_eng_reg;

    // Stage enables: a stage loads when empty or when the next one moves
    assign en_out     = !v_out_reg || result.ready;
    assign en_mul     = !v_mul_reg || en_out;
    assign en_avg     = !v_avg_reg || en_mul;
    assign en_div     = !v_div_reg || en_avg;
    assign sums_ready = en_div;

    always_comb
    begin
        v_div_next = en_div ? sums_valid : v_div_reg;
        v_avg_next = en_avg ? v_div_reg  : v_avg_reg;
        v_mul_next = en_mul ? v_avg_reg  : v_mul_reg;
        v_out_next = en_out ? v_mul_reg  : v_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_div_reg <= 1'b0;
            v_avg_reg <= 1'b0;
            v_mul_reg <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            v_div_reg <= v_div_next;
            v_avg_reg <= v_avg_next;
            v_mul_reg <= v_mul_next;
            v_out_reg <= v_out_next;
        end
    end

    // Stage 1: sum times reciprocal of the window size
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            div_prod[ch] = DIV_PROD_W'(sums[ch]) * DIV_PROD_W'(DIV_RECIP);
        end
    end

    // Stage 2: quotient estimate is low by at most one; fix with one compare
    always_comb
    begin
        logic [SUM_W-1:0] q_est;
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] q_fix;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            q_est        = div_prod_reg[ch][DIV_PROD_W-1 -: SUM_W];
            rem          = div_sum_reg[ch] - SUM_W'(q_est * SUM_W'(WINDOW));
            q_fix        = q_est + SUM_W'(rem >= SUM_W'(WINDOW));
            avg_calc[ch] = q_fix[SAMPLE_BITS-1:0];
        end
    end

    // Stage 3: average times gain; the last channel is the bus voltage
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            mul_prod[ch] = MUL_W'(avg_reg[ch])
                         * MUL_W'((ch == CHANNELS - 1) ? gains.voltage : gains.current);
        end
    end

    // Stage 4: drop the Q16 fraction and saturate to the field width
    always_comb
    begin
        logic [SHR_W-1:0] shr;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            shr = mul_prod_reg[ch][MUL_W-1:GAIN_FRAC];
            if (ch == CHANNELS - 1)
            begin
                eng_calc[ch] = (shr > SHR_W'({VOLT_W{1'b1}})) ? {VOLT_W{1'b1}}
                                                             : VOLT_W'(shr);
            end
            else
            begin
                eng_calc[ch] = (shr > SHR_W'({CUR_W{1'b1}})) ? VOLT_W'({CUR_W{1'b1}})
                                                            : VOLT_W'(shr);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en_div)
        begin
            div_prod_reg <= div_prod;
            div_sum_reg  <= sums;
        end
        if (en_avg)
        begin
            avg_reg <= avg_calc;
        end
        if (en_mul)
        begin
            mul_prod_reg <= mul_prod;
            mul_avg_reg  <= avg_reg;
        end
        if (en_out)
        begin
            out_avg_reg <= mul_avg_reg;
            out_eng_reg <= eng_calc;
        end
    end

    assign result.valid          = v_out_reg;
    assign result.average_a      = out_avg_reg[0];
    assign result.average_b      = out_avg_reg[1];
    assign result.average_c      = out_avg_reg[2];
    assign result.average_d      = out_avg_reg[3];
    assign result.average_bus    = out_avg_reg[4];
    assign result.current_a_ma   = out_eng_reg[0][CUR_W-1:0];
    assign result.current_b_ma   = out_eng_reg[1][CUR_W-1:0];
    assign result.current_c_ma   = out_eng_reg[2][CUR_W-1:0];
    assign result.current_d_ma   = out_eng_reg[3][CUR_W-1:0];
    assign result.bus_voltage_mv = out_eng_reg[4];

endmodule

`default_nettype wire

// File: rtl/core/multichannel_moving_average_scaler.sv
// Path: window stage 1 and sum register, then scale stages div, avg, mul and out.
// Throughput: one scan word per cycle unless results stall; each scan does one read and
// one write of a window RAM row (one row holds all channels), on separate RAM ports.
// Reset: window rows read as zero until first written (per-row valid bits, no
// clearing pass), running sums and window position cleared, gains at defaults.
`default_nettype none

module multichannel_moving_average_scaler (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mmas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mmas_pkg::GAIN_W-1:0]        cfg_data,
    scan_if.sink                                    scan,
    result_if.source                                result
);
    import mmas_pkg::*;

    logic       sums_valid;
    logic       sums_ready;
    sum_vec_t   sums;
    gain_cfg_t  gain_reg, gain_next;

    // Gain registers
    always_comb
    begin
        gain_next = gain_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CURRENT_GAIN: gain_next.current = cfg_data;
                CFG_VOLTAGE_GAIN: gain_next.voltage = cfg_data;
                default:          gain_next = gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg.current <= CURRENT_GAIN_RST;
            gain_reg.voltage <= VOLTAGE_GAIN_RST;
        end
        else
        begin
            gain_reg <= gain_next;
        end
    end

    mmas_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .sums_valid (sums_valid),
        .sums_ready (sums_ready),
        .sums       (sums)
    );

    mmas_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .sums_valid (sums_valid),
        .sums_ready (sums_ready),
        .sums       (sums),
        .gains      (gain_reg),
        .result     (result)
    );

endmodule

`default_nettype wire
